@@ sv/assert_macros.svh @@
// assertion macros used by the generator rtl
// no dependencies; define ASSERT_OFF to drop all checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// concurrent implication checked at every edge out of reset
`define SBM_ASSERT(lbl, ck, rn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);
// checked at every edge, including reset
`define SBM_ASSERT_ALWAYS(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);
`else
`define SBM_ASSERT(lbl, ck, rn, prop, msg)
`define SBM_ASSERT_ALWAYS(lbl, ck, prop, msg)
`endif
`endif

@@ sv/sbm_pkg.sv @@
// shared types, constants and face tables for the box mesh generator
// no dependencies
package sbm_pkg;

  localparam int SizeW  = 24;
  localparam int SegW   = 9;
  localparam int IdxW   = 19;
  localparam int PosW   = 25;
  localparam int QuotW  = 25;
  localparam int NumW   = QuotW + 10;
  localparam int DenW   = 10;
  localparam logic [SegW-1:0] MaxSeg = 9'd256;
  localparam logic [2:0] LastFace = 3'd5;

  localparam logic [2:0] REG_WIDTH  = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_DEPTH  = 3'd2;
  localparam logic [2:0] REG_SEGX   = 3'd3;
  localparam logic [2:0] REG_SEGY   = 3'd4;
  localparam logic [2:0] REG_SEGZ   = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO_SZ  = 2'd1;
  localparam logic [1:0] ST_ZERO_SEG = 2'd2;

  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SETUP  = 5'b00010,
    S_MUL    = 5'b00100,
    S_DIV    = 5'b01000,
    S_FIN    = 5'b10000
  } state_t;

  function automatic logic [1:0] u_axis(input logic [2:0] f);
    logic [1:0] a;
    case (f)
      3'd2, 3'd3: a = AX_Z;
      default:    a = AX_X;
    endcase
    return a;
  endfunction

  function automatic logic [1:0] v_axis(input logic [2:0] f);
    logic [1:0] a;
    case (f)
      3'd4, 3'd5: a = AX_Z;
      default:    a = AX_Y;
    endcase
    return a;
  endfunction

  // corner bits (x in bit 0) of quad slot 0, 1 and 3 of each face
  function automatic logic [2:0] corner_c1(input logic [2:0] f);
    logic [2:0] c;
    case (f)
      3'd0: c = 3'b000;
      3'd1: c = 3'b101;
      3'd2: c = 3'b100;
      3'd3: c = 3'b001;
      3'd4: c = 3'b100;
      default: c = 3'b010;
    endcase
    return c;
  endfunction

  function automatic logic [2:0] corner_c2(input logic [2:0] f);
    logic [2:0] c;
    case (f)
      3'd0: c = 3'b001;
      3'd1: c = 3'b100;
      3'd2: c = 3'b000;
      3'd3: c = 3'b101;
      3'd4: c = 3'b101;
      default: c = 3'b011;
    endcase
    return c;
  endfunction

  function automatic logic [2:0] corner_c4(input logic [2:0] f);
    logic [2:0] c;
    case (f)
      3'd0: c = 3'b010;
      3'd1: c = 3'b111;
      3'd2: c = 3'b110;
      3'd3: c = 3'b011;
      3'd4: c = 3'b000;
      default: c = 3'b110;
    endcase
    return c;
  endfunction

endpackage

@@ sv/sbm_div.sv @@
// radix-2 restoring divider, one quotient bit per cycle
// depends on sbm_pkg; quotient must fit QuotW bits
module sbm_div
  import sbm_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [NumW-1:0] num,
  input  logic [DenW-1:0] den,
  output logic            busy,
  output logic            done,
  output logic [QuotW-1:0] quot
);

  logic [DenW-1:0]  rem_r, rem_nxt;
  logic [QuotW-1:0] q_r, q_nxt;
  logic [4:0]       cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  logic [DenW:0]    trial;

  always_comb begin
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    trial    = {rem_r, q_r[QuotW-1]};
    if (start) begin
      rem_nxt = num[NumW-1:QuotW];
      q_nxt   = num[QuotW-1:0];
      cnt_nxt = 5'(QuotW);
    end else if (cnt_r != 5'd0) begin
      if (trial >= {1'b0, den}) begin
        rem_nxt = DenW'(trial - {1'b0, den});
        q_nxt   = {q_r[QuotW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DenW-1:0];
        q_nxt   = {q_r[QuotW-2:0], 1'b0};
      end
      cnt_nxt  = cnt_r - 5'd1;
      done_nxt = (cnt_r == 5'd1);
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    if (!rst_n) begin
      cnt_r  <= 5'd0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  assign busy = (cnt_r != 5'd0);
  assign done = done_r;
  assign quot = q_r;

endmodule

@@ sv/subdivided_box_mesh_generator.sv @@
// box mesh vertex generator: one vertex per input transaction
// per vertex: accept, setup, then two rounded divisions (multiply, load, 25 divide steps,
// done) and a finish step that holds until the output register is free, then out_tvalid
// a new transaction is accepted while the previous result still waits on the output
// rst_n (synchronous) restores the default box and the first vertex of the front face
`include "assert_macros.svh"
module subdivided_box_mesh_generator
  import sbm_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [0] restart
  output logic         out_tvalid,
  input  logic         out_tready,
  // pos_x, pos_y, pos_z, vertex_number, corner_bl, corner_br, corner_tl, corner_tr
  output logic [175:0] out_tdata,
  output logic [2:0]   out_tuser,  // cell_valid, status
  output logic         out_tlast,  // last_vertex
  input  logic         cfg_wr_en,
  input  logic [2:0]   cfg_addr,
  input  logic [23:0]  cfg_wdata
);

  state_t state_r, state_nxt;

  logic [SizeW-1:0] wid_r, hgt_r, dep_r;
  logic [SegW-1:0]  segx_r, segy_r, segz_r;

  logic [2:0]      face_r, face_nxt;
  logic [SegW-1:0] u_r, u_nxt, v_r, v_nxt;
  logic [IdxW-1:0] vcnt_r, vcnt_nxt, fsv_r, fsv_nxt;

  logic            restart_r;
  logic [1:0]      err_r, err_nxt;
  logic [SegW-1:0] useg_r, useg_nxt, vseg_r, vseg_nxt;
  logic            term_r, term_nxt;
  logic            launch_r, launch_nxt;
  logic [NumW-1:0] num_r, num_nxt;
  logic [QuotW-1:0] qu_r, qu_nxt, qv_r, qv_nxt;

  logic            ov_r, ov_nxt;
  logic [175:0]    od_r, od_nxt;
  logic [2:0]      ou_r, ou_nxt;
  logic            ol_r, ol_nxt;

  logic            div_busy, div_done;
  logic [QuotW-1:0] div_q;

  sbm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (launch_r),
    .num   (num_r),
    .den   ({term_r ? vseg_r : useg_r, 1'b0}),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_q)
  );

  function automatic logic [SegW-1:0] clamp_seg(input logic [SegW-1:0] s);
    return (s > MaxSeg) ? MaxSeg : s;
  endfunction

  function automatic logic [SegW-1:0] seg_of(input logic [1:0] a, input logic [SegW-1:0] sx,
                                             input logic [SegW-1:0] sy,
                                             input logic [SegW-1:0] sz);
    logic [SegW-1:0] s;
    case (a)
      AX_X:    s = sx;
      AX_Y:    s = sy;
      default: s = sz;
    endcase
    return s;
  endfunction

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wid_r  <= 24'd256;
      hgt_r  <= 24'd256;
      dep_r  <= 24'd256;
      segx_r <= 9'd1;
      segy_r <= 9'd1;
      segz_r <= 9'd1;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_WIDTH:  wid_r  <= cfg_wdata;
        REG_HEIGHT: hgt_r  <= cfg_wdata;
        REG_DEPTH:  dep_r  <= cfg_wdata;
        REG_SEGX:   segx_r <= cfg_wdata[SegW-1:0];
        REG_SEGY:   segy_r <= cfg_wdata[SegW-1:0];
        REG_SEGZ:   segz_r <= cfg_wdata[SegW-1:0];
        default: ;
      endcase
    end
  end

  logic [2:0]       f_w;
  logic [SegW-1:0]  u_w, v_w, us_w, vs_w, idx_w;
  logic [IdxW-1:0]  vc_w, fs_w;
  logic [1:0]       ax_w;
  logic [SizeW-1:0] h_w;
  logic signed [26:0] pos_w [3];
  logic [2:0]       c1_w, c2_w, c4_w;
  logic [1:0]       uax_w, vax_w;
  logic [IdxW-1:0]  bl_w, tl_w;
  logic [SegW:0]    row_w;
  logic             cell_w;
  logic [SizeW-1:0] hv_w [3];

  always_comb begin
    state_nxt  = state_r;
    face_nxt   = face_r;
    u_nxt      = u_r;
    v_nxt      = v_r;
    vcnt_nxt   = vcnt_r;
    fsv_nxt    = fsv_r;
    err_nxt    = err_r;
    useg_nxt   = useg_r;
    vseg_nxt   = vseg_r;
    term_nxt   = term_r;
    launch_nxt = 1'b0;
    num_nxt    = num_r;
    qu_nxt     = qu_r;
    qv_nxt     = qv_r;
    ov_nxt     = ov_r && !out_tready;
    od_nxt     = od_r;
    ou_nxt     = ou_r;
    ol_nxt     = ol_r;

    f_w = face_r; u_w = u_r; v_w = v_r; vc_w = vcnt_r; fs_w = fsv_r;
    us_w = '0; vs_w = '0;
    hv_w[0] = wid_r; hv_w[1] = hgt_r; hv_w[2] = dep_r;
    uax_w = u_axis(face_r);
    vax_w = v_axis(face_r);
    ax_w  = term_r ? vax_w : uax_w;
    h_w   = hv_w[ax_w];
    idx_w = term_r ? v_r : u_r;
    c1_w  = corner_c1(face_r);
    c2_w  = corner_c2(face_r);
    c4_w  = corner_c4(face_r);
    row_w = {1'b0, useg_r} + 10'd1;
    bl_w  = IdxW'(fsv_r + IdxW'(v_r * row_w) + IdxW'(u_r));
    tl_w  = IdxW'(bl_w + IdxW'(row_w));
    cell_w = (u_r < useg_r) && (v_r < vseg_r);
    for (int a = 0; a < 3; a++) begin
      pos_w[a] = c1_w[a] ? $signed({3'b000, hv_w[a]}) : -$signed({3'b000, hv_w[a]});
      if (a == int'(uax_w))
        pos_w[a] = c2_w[a] ? pos_w[a] + $signed({2'b00, qu_r})
                           : pos_w[a] - $signed({2'b00, qu_r});
      if (a == int'(vax_w))
        pos_w[a] = c4_w[a] ? pos_w[a] + $signed({2'b00, qv_r})
                           : pos_w[a] - $signed({2'b00, qv_r});
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_SETUP;
      end
      S_SETUP: begin
        if (restart_r) begin
          f_w = '0; u_w = '0; v_w = '0; vc_w = '0; fs_w = '0;
        end
        if (wid_r == '0 || hgt_r == '0 || dep_r == '0) err_nxt = ST_ZERO_SZ;
        else if (segx_r == '0 || segy_r == '0 || segz_r == '0) err_nxt = ST_ZERO_SEG;
        else err_nxt = ST_OK;
        if (f_w > LastFace) f_w = LastFace;
        us_w = clamp_seg(seg_of(u_axis(f_w), segx_r, segy_r, segz_r));
        vs_w = clamp_seg(seg_of(v_axis(f_w), segx_r, segy_r, segz_r));
        if (u_w > us_w) u_w = us_w;
        if (v_w > vs_w) v_w = vs_w;
        face_nxt = f_w; u_nxt = u_w; v_nxt = v_w; vcnt_nxt = vc_w; fsv_nxt = fs_w;
        useg_nxt = us_w;
        vseg_nxt = vs_w;
        term_nxt = 1'b0;
        state_nxt = (err_nxt != ST_OK) ? S_FIN : S_MUL;
      end
      S_MUL: begin
        // numerator 4*idx*half + seg over 2*seg rounds idx*2*half/seg to nearest
        num_nxt = NumW'(idx_w * {h_w, 2'b00}) + NumW'(term_r ? vseg_r : useg_r);
        launch_nxt = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          if (term_r) begin
            qv_nxt = div_q;
            state_nxt = S_FIN;
          end else begin
            qu_nxt = div_q;
            term_nxt = 1'b1;
            state_nxt = S_MUL;
          end
        end
      end
      S_FIN: begin
        if (!ov_r || out_tready) begin
          ov_nxt = 1'b1;
          state_nxt = S_IDLE;
          if (err_r != ST_OK) begin
            od_nxt = '0;
            ou_nxt = {err_r, 1'b0};
            ol_nxt = 1'b0;
            face_nxt = '0; u_nxt = '0; v_nxt = '0; vcnt_nxt = '0; fsv_nxt = '0;
          end else begin
            od_nxt = {6'd0,
                      cell_w ? IdxW'(tl_w + 19'd1) : '0,
                      cell_w ? tl_w : '0,
                      cell_w ? IdxW'(bl_w + 19'd1) : '0,
                      cell_w ? bl_w : '0,
                      vcnt_r,
                      pos_w[2][PosW-1:0], pos_w[1][PosW-1:0], pos_w[0][PosW-1:0]};
            ou_nxt = {ST_OK, cell_w};
            ol_nxt = 1'b0;
            if (u_r < useg_r) begin
              u_nxt = u_r + 9'd1;
              vcnt_nxt = vcnt_r + 19'd1;
            end else if (v_r < vseg_r) begin
              u_nxt = '0;
              v_nxt = v_r + 9'd1;
              vcnt_nxt = vcnt_r + 19'd1;
            end else if (face_r < LastFace) begin
              u_nxt = '0;
              v_nxt = '0;
              face_nxt = face_r + 3'd1;
              vcnt_nxt = vcnt_r + 19'd1;
              fsv_nxt = vcnt_r + 19'd1;
            end else begin
              ol_nxt = 1'b1;
              face_nxt = '0; u_nxt = '0; v_nxt = '0; vcnt_nxt = '0; fsv_nxt = '0;
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    err_r  <= err_nxt;
    useg_r <= useg_nxt;
    vseg_r <= vseg_nxt;
    term_r <= term_nxt;
    num_r  <= num_nxt;
    qu_r   <= qu_nxt;
    qv_r   <= qv_nxt;
    od_r   <= od_nxt;
    ou_r   <= ou_nxt;
    ol_r   <= ol_nxt;
    if (state_r == S_IDLE) restart_r <= in_tdata[0];
    if (!rst_n) begin
      state_r  <= S_IDLE;
      face_r   <= '0;
      u_r      <= '0;
      v_r      <= '0;
      vcnt_r   <= '0;
      fsv_r    <= '0;
      launch_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      face_r   <= face_nxt;
      u_r      <= u_nxt;
      v_r      <= v_nxt;
      vcnt_r   <= vcnt_nxt;
      fsv_r    <= fsv_nxt;
      launch_r <= launch_nxt;
      ov_r     <= ov_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tuser  = ou_r;
  assign out_tlast  = ol_r;

  `SBM_ASSERT(a_idle_div, clk, rst_n, in_tready |-> !div_busy, "divider busy while idle")
  `SBM_ASSERT(a_done_state, clk, rst_n, div_done |-> (state_r == S_DIV), "divider done out of sequence")
  `SBM_ASSERT(a_err_zero, clk, rst_n, (ov_r && ou_r[2:1] != ST_OK) |-> (od_r == '0 && !ol_r), "error result carries data")

endmodule

@@ verif/subdivided_box_mesh_generator_tb.sv @@
// testbench for the box mesh vertex generator: directed table, then random walks
// across many box settings; each vertex is checked against a local predictor or
// a typed table row; depends on sbm_pkg and the subdivided_box_mesh_generator rtl
module subdivided_box_mesh_generator_tb;
  import sbm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [24:0] px, py, pz;
    logic [18:0] vnum;
    logic        has_cell;
    logic [18:0] bl, br, tl, tr;
    logic        last;
    logic [1:0]  st;
  } vertex_t;

  typedef struct packed {
    logic        restart;
    logic        wr;
    logic [2:0]  addr;
    logic [23:0] val;
    logic        typed;
    vertex_t     v;
  } row_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata = '0;     // [0] restart
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  // pos_x, pos_y, pos_z, vertex_number, corner_bl, corner_br, corner_tl, corner_tr
  logic [175:0] out_tdata;
  logic [2:0]   out_tuser;         // cell_valid, status
  logic         out_tlast;         // last_vertex
  logic         cfg_wr_en = 1'b0;
  logic [2:0]   cfg_addr = '0;
  logic [23:0]  cfg_wdata = '0;

  subdivided_box_mesh_generator uut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  logic [23:0] box_w, box_h, box_d;
  logic [8:0]  seg_x, seg_y, seg_z;
  int unsigned face, u_pos, v_pos, vcount, face_base;

  // corner bit patterns (x in bit 0) and the quad of each face
  const int unsigned corner_mask[8] = '{0, 1, 3, 2, 4, 5, 7, 6};
  const int unsigned quad_c1[6] = '{0, 5, 4, 1, 4, 3};
  const int unsigned quad_c2[6] = '{1, 4, 0, 5, 5, 2};
  const int unsigned quad_c4[6] = '{3, 6, 7, 2, 0, 7};
  const int unsigned grid_u[6] = '{0, 0, 2, 2, 0, 0};
  const int unsigned grid_v[6] = '{1, 1, 1, 1, 2, 2};

  vertex_t     vertex_q[$];
  int          errors = 0;
  int          n_items = 0, n_checked = 0, n_last = 0, n_err_status = 0;
  bit          hold_off = 1'b0;
  bit          no_gaps = 1'b0;
  longint      cycles = 0;

  function automatic longint rounded_share(int unsigned idx, longint span, int unsigned seg);
    longint mag;
    longint q;
    mag = (span < 0) ? -span : span;
    q = (longint'(idx) * mag * 2 + seg) / (longint'(seg) * 2);
    return (span < 0) ? -q : q;
  endfunction

  function automatic int unsigned seg_limit(logic [8:0] s);
    return (s > MaxSeg) ? 256 : int'(s);
  endfunction

  task automatic rewind_walk();
    face = 0; u_pos = 0; v_pos = 0; vcount = 0; face_base = 0;
  endtask

  task automatic apply_reg(logic [2:0] a, logic [23:0] d);
    case (a)
      REG_WIDTH:  box_w = d;
      REG_HEIGHT: box_h = d;
      REG_DEPTH:  box_d = d;
      REG_SEGX:   seg_x = d[8:0];
      REG_SEGY:   seg_y = d[8:0];
      REG_SEGZ:   seg_z = d[8:0];
      default: ;
    endcase
  endtask

  task automatic next_vertex(logic restart, output vertex_t v);
    int unsigned segs[3];
    longint      halfs[3];
    int unsigned us, vs, row_len, base;
    longint      c1, c2, c4, p;
    v = '0;
    if (restart) rewind_walk();
    if (box_w == 0 || box_h == 0 || box_d == 0) begin
      v.st = ST_ZERO_SZ;
      rewind_walk();
      return;
    end
    if (seg_x == 0 || seg_y == 0 || seg_z == 0) begin
      v.st = ST_ZERO_SEG;
      rewind_walk();
      return;
    end
    segs[0] = seg_limit(seg_x); segs[1] = seg_limit(seg_y); segs[2] = seg_limit(seg_z);
    halfs[0] = box_w; halfs[1] = box_h; halfs[2] = box_d;
    if (face > 5) face = 5;
    us = segs[grid_u[face]];
    vs = segs[grid_v[face]];
    if (u_pos > us) u_pos = us;
    if (v_pos > vs) v_pos = vs;
    for (int ax = 0; ax < 3; ax++) begin
      c1 = (corner_mask[quad_c1[face]] & (1 << ax)) ? halfs[ax] : -halfs[ax];
      c2 = (corner_mask[quad_c2[face]] & (1 << ax)) ? halfs[ax] : -halfs[ax];
      c4 = (corner_mask[quad_c4[face]] & (1 << ax)) ? halfs[ax] : -halfs[ax];
      p = c1 + rounded_share(u_pos, c2 - c1, us) + rounded_share(v_pos, c4 - c1, vs);
      if (ax == 0) v.px = p[24:0];
      else if (ax == 1) v.py = p[24:0];
      else v.pz = p[24:0];
    end
    v.vnum = vcount[18:0];
    if (u_pos < us && v_pos < vs) begin
      row_len = us + 1;
      base = face_base + v_pos * row_len + u_pos;
      v.has_cell = 1'b1;
      v.bl = base[18:0];
      v.br = 19'(base + 1);
      v.tl = 19'(base + row_len);
      v.tr = 19'(base + row_len + 1);
    end
    if (u_pos < us) begin
      u_pos++;
      vcount = (vcount + 1) & 32'h7FFFF;
    end else if (v_pos < vs) begin
      u_pos = 0;
      v_pos++;
      vcount = (vcount + 1) & 32'h7FFFF;
    end else if (face < 5) begin
      u_pos = 0;
      v_pos = 0;
      face++;
      vcount = (vcount + 1) & 32'h7FFFF;
      face_base = vcount;
    end else begin
      v.last = 1'b1;
      rewind_walk();
    end
  endtask

  task automatic wait_drained();
    if (in_tvalid) in_tvalid <= 1'b0;
    while (vertex_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] a, logic [23:0] d);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= a;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    apply_reg(a, d);
  endtask

  // offers one transaction; valid stays high across back-to-back items
  task automatic send_vertex(logic restart, logic typed, vertex_t typed_v);
    int unsigned gap;
    vertex_t v;
    gap = no_gaps ? 0 : $urandom_range(0, 16);
    if (gap > 0 && in_tvalid) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'(($urandom() & 1) ? 7'h00 : 7'h7F) & 7'h00, restart};
    do @(posedge clk); while (!in_tready);
    next_vertex(restart, v);
    vertex_q.push_back(typed ? typed_v : v);
    n_items++;
  endtask

  task automatic random_config();
    logic [23:0] d;
    for (int r = 0; r <= 5; r++) begin
      if (r <= 2) begin
        case ($urandom_range(0, 9))
          0: d = 24'hFFFFFF;
          1: d = 24'd1;
          2: d = '0;
          default: d = 24'($urandom());
        endcase
      end else begin
        case ($urandom_range(0, 11))
          0: d = 24'd256;
          1: d = 24'(24'(9'h1FF) | ($urandom() & 24'hFFFE00));
          2: d = '0;
          3: d = 24'(24'(257) | ($urandom() & 24'hFFFE00));
          default: d = 24'(24'($urandom_range(1, 4)) | ($urandom() & 24'hFFFE00));
        endcase
      end
      write_reg(r[2:0], d);
    end
  endtask

  // expected vertex for directed rows that can be read off directly
  function automatic vertex_t typed_vertex(logic [24:0] x, y, z, logic [18:0] n,
                                           logic has_cell, logic [18:0] b);
    vertex_t v;
    v = '0;
    v.px = x; v.py = y; v.pz = z; v.vnum = n; v.has_cell = has_cell;
    if (has_cell) begin
      v.bl = b; v.br = b + 19'd1; v.tl = b + 19'd2; v.tr = b + 19'd3;
    end
    v.st = ST_OK;
    return v;
  endfunction

  function automatic vertex_t error_vertex(logic [1:0] s);
    vertex_t v;
    v = '0;
    v.st = s;
    return v;
  endfunction

  row_t directed[$];

  initial begin
    vertex_t none;
    none = '0;
    box_w = 24'd256; box_h = 24'd256; box_d = 24'd256;
    seg_x = 9'd1; seg_y = 9'd1; seg_z = 9'd1;
    rewind_walk();
    // after reset: default box, all four vertices of the front face, the first two typed
    directed.push_back('{1'b0, 1'b0, REG_WIDTH, 24'd0, 1'b1,
                         typed_vertex(-25'sd256, -25'sd256, -25'sd256, 19'd0, 1'b1, 19'd0)});
    directed.push_back('{1'b0, 1'b0, REG_WIDTH, 24'd0, 1'b1,
                         typed_vertex(25'sd256, -25'sd256, -25'sd256, 19'd1, 1'b0, 19'd0)});
    directed.push_back('{1'b0, 1'b0, REG_WIDTH, 24'd0, 1'b0, none});
    directed.push_back('{1'b0, 1'b0, REG_WIDTH, 24'd0, 1'b0, none});
    // zero size, then zero segments (size check wins when both apply)
    directed.push_back('{1'b0, 1'b1, REG_WIDTH, 24'd0, 1'b0, none});
    directed.push_back('{1'b0, 1'b1, REG_SEGX, 24'd0, 1'b0, none});
    directed.push_back('{1'b0, 1'b0, REG_WIDTH, 24'd0, 1'b1, error_vertex(ST_ZERO_SZ)});
    directed.push_back('{1'b0, 1'b1, REG_WIDTH, 24'hFFFFFF, 1'b0, none});
    directed.push_back('{1'b1, 1'b0, REG_WIDTH, 24'd0, 1'b1, error_vertex(ST_ZERO_SEG)});
    // largest box, segment count above the limit
    directed.push_back('{1'b0, 1'b1, REG_HEIGHT, 24'hFFFFFF, 1'b0, none});
    directed.push_back('{1'b0, 1'b1, REG_DEPTH, 24'hFFFFFF, 1'b0, none});
    directed.push_back('{1'b0, 1'b1, REG_SEGX, 24'h0001FF, 1'b0, none});
    directed.push_back('{1'b0, 1'b1, REG_SEGY, 24'd256, 1'b0, none});
    directed.push_back('{1'b0, 1'b1, REG_SEGZ, 24'd3, 1'b0, none});
    for (int i = 0; i < 4; i++) directed.push_back('{1'b0, 1'b0, REG_WIDTH, 24'd0, 1'b0, none});
    // grid shrinks mid-walk: positions clamp
    directed.push_back('{1'b0, 1'b1, REG_SEGX, 24'd1, 1'b0, none});
    for (int i = 0; i < 3; i++) directed.push_back('{1'b0, 1'b0, REG_WIDTH, 24'd0, 1'b0, none});
    directed.push_back('{1'b1, 1'b0, REG_WIDTH, 24'd0, 1'b0, none});
    directed.push_back('{1'b0, 1'b0, REG_WIDTH, 24'd0, 1'b0, none});

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].wr) begin
        wait_drained();
        write_reg(directed[i].addr, directed[i].val);
      end else begin
        send_vertex(directed[i].restart, directed[i].typed, directed[i].v);
      end
    end

    // walks of mostly small meshes: default settings in phase 0, random ones in most others
    for (int ph = 0; ph < 10; ph++) begin
      wait_drained();
      if (ph == 0) begin
        write_reg(REG_WIDTH, 24'd256); write_reg(REG_HEIGHT, 24'd256);
        write_reg(REG_DEPTH, 24'd256); write_reg(REG_SEGX, 24'd1);
        write_reg(REG_SEGY, 24'd1);   write_reg(REG_SEGZ, 24'd1);
      end else if (ph != 6) begin
        // phase 6 keeps the walk position and only rewrites the x and y segment counts
        random_config();
      end else begin
        write_reg(REG_SEGX, 24'd1); write_reg(REG_SEGY, 24'd2);
      end
      no_gaps = (ph == 3 || ph == 7);
      for (int k = 0; k < 48; k++) begin
        if (ph == 2 && k == 10) hold_off = 1'b1;
        if (ph == 5 && k == 20) wait_drained();
        send_vertex(($urandom_range(0, 19) == 0), 1'b0, none);
      end
    end
    in_tvalid <= 1'b0;
    while (vertex_q.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    $display("%0d vertices sent, %0d checked, %0d mesh ends, %0d error results",
             n_items, n_checked, n_last, n_err_status);
    $display("covered default, largest, zero and clamped box settings with random stalls");
    if (errors == 0)
      $display("subdivided_box_mesh_generator test passed");
    else
      $display("subdivided_box_mesh_generator test failed");
    $finish;
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    int unsigned stall;
    vertex_t got, want;
    @(posedge rst_n);
    forever begin
      if (hold_off) begin
        stall = 400;
        hold_off = 1'b0;
      end else begin
        stall = no_gaps ? 0 : $urandom_range(0, 16);
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      got.px = out_tdata[24:0];     got.py = out_tdata[49:25];
      got.pz = out_tdata[74:50];    got.vnum = out_tdata[93:75];
      got.bl = out_tdata[112:94];   got.br = out_tdata[131:113];
      got.tl = out_tdata[150:132];  got.tr = out_tdata[169:151];
      got.has_cell = out_tuser[0];  got.st = out_tuser[2:1];
      got.last = out_tlast;
      if (vertex_q.size() == 0) begin
        $display("%0t: unexpected vertex transaction, actual %h", $time, got);
        errors++;
      end else begin
        want = vertex_q.pop_front();
        n_checked++;
        if (want.last) n_last++;
        if (want.st != ST_OK) n_err_status++;
        if (got !== want) begin
          errors++;
          $display("%0t: vertex mismatch (x y z num cell bl br tl tr last status)", $time);
          $display("  expected %h %h %h %0d %b %0d %0d %0d %0d %b %0d", want.px, want.py,
                   want.pz, want.vnum, want.has_cell, want.bl, want.br, want.tl, want.tr,
                   want.last, want.st);
          $display("  actual   %h %h %h %0d %b %0d %0d %0d %0d %b %0d", got.px, got.py,
                   got.pz, got.vnum, got.has_cell, got.bl, got.br, got.tl, got.tr,
                   got.last, got.st);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == 600000) begin
      $display("timeout with %0d vertices outstanding", vertex_q.size());
      $display("subdivided_box_mesh_generator test failed");
      $finish;
    end
  end

endmodule

@@ filelist.f @@
+incdir+sv
sv/sbm_pkg.sv
sv/sbm_div.sv
sv/subdivided_box_mesh_generator.sv
verif/subdivided_box_mesh_generator_tb.sv
